// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the RTL files that check their own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every rising clock edge outside reset.
`define DEQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DEQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/deq_pkg.sv -----
// Package: widths, codes, state and struct types of the double-ended queue engine.
package deq_pkg;

   localparam int DEPTH_DEFAULT = 1024;
   localparam int ACTION_W      = 3;
   localparam int WORD_W        = 32;
   localparam int KIND_W        = 2;
   localparam int FILL_W        = 11;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH_BACK  = 3'd0,
      ACT_PUSH_FRONT = 3'd1,
      ACT_SIZE       = 3'd2,
      ACT_POP_FRONT  = 3'd3,
      ACT_POP_BACK   = 3'd4,
      ACT_PEEK_FRONT = 3'd5,
      ACT_PEEK_BACK  = 3'd6,
      ACT_CLEAR      = 3'd7
   } action_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_OK    = 2'd0,
      KIND_WORD  = 2'd1,
      KIND_EMPTY = 2'd2,
      KIND_FULL  = 2'd3
   } kind_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_READ = 1'b1
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;
      logic load_read;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic read_hit;
   } dp_status_type;

endpackage

// ----- hw/rtl/deq_ifs.sv -----
// Valid/ready channel interfaces for the request and response sides.
interface deq_req_if;
   logic                                valid;
   logic                                ready;
   logic [deq_pkg::ACTION_W-1:0]        action;
   logic signed [deq_pkg::WORD_W-1:0]   push_value;

   modport source (output valid, action, push_value, input ready);
   modport sink   (input valid, action, push_value, output ready);
endinterface

interface deq_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [deq_pkg::KIND_W-1:0]          result_kind;
   logic signed [deq_pkg::WORD_W-1:0]   data_word;
   logic [deq_pkg::FILL_W-1:0]          fill_count;

   modport source (output valid, result_kind, data_word, fill_count, input ready);
   modport sink   (input valid, result_kind, data_word, fill_count, output ready);
endinterface

// ----- hw/rtl/deq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/deq_ctrl.sv -----
// Controller: handshake state machine sequencing accepts and store reads.
module deq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  deq_pkg::dp_status_type stat,
   output deq_pkg::ctrl_cmd_type  cmd
);

   deq_pkg::state_type state_ff, state_in;
   logic               out_valid_ff, out_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= deq_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      cmd.accept    = 1'b0;
      cmd.load_read = 1'b0;
      unique case (state_ff)
         deq_pkg::ST_IDLE: begin
            // take a request when the response slot is free or draining now
            req_ready  = !out_valid_ff || rsp_ready;
            cmd.accept = req_valid && req_ready;
            if (cmd.accept && stat.read_hit) begin
               state_in = deq_pkg::ST_READ;
            end
         end
         deq_pkg::ST_READ: begin
            cmd.load_read = 1'b1;
            state_in      = deq_pkg::ST_IDLE;
         end
         default: begin
            state_in = deq_pkg::ST_IDLE;
         end
      endcase

      priority if ((cmd.accept && !stat.read_hit) || cmd.load_read) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

// ----- hw/rtl/deq_dpath.sv -----
// Datapath: ring pointers, entry count, entry store and response registers.
module deq_dpath #(
   parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [deq_pkg::ACTION_W-1:0]       action,
   input  logic signed [deq_pkg::WORD_W-1:0]  push_value,
   input  deq_pkg::ctrl_cmd_type              cmd,
   output deq_pkg::dp_status_type             stat,
   output logic [deq_pkg::KIND_W-1:0]         result_kind,
   output logic signed [deq_pkg::WORD_W-1:0]  data_word,
   output logic [deq_pkg::FILL_W-1:0]         fill_count
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [IDX_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] head_next, head_prev, tail_next, tail_prev;
   logic             empty, full;

   deq_pkg::action_type act;
   deq_pkg::kind_type   kind;

   logic                      wr_req, rd_req;
   logic [IDX_W-1:0]          wr_addr, rd_addr;
   logic [deq_pkg::WORD_W-1:0] rd_data;

   logic [deq_pkg::KIND_W-1:0]        kind_ff;
   logic signed [deq_pkg::WORD_W-1:0] data_ff;
   logic [deq_pkg::FILL_W-1:0]        fill_ff;

   assign act   = deq_pkg::action_type'(action);
   assign empty = (count_ff == '0);
   assign full  = (count_ff == CNT_W'(DEPTH));

   // ring wrap by compare so depths that are not a power of two work
   assign head_next = (head_ff == IDX_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign head_prev = (head_ff == '0) ? IDX_W'(DEPTH - 1) : head_ff - 1'b1;
   assign tail_next = (tail_ff == IDX_W'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
   assign tail_prev = (tail_ff == '0) ? IDX_W'(DEPTH - 1) : tail_ff - 1'b1;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      wr_req   = 1'b0;
      wr_addr  = tail_ff;
      rd_req   = 1'b0;
      rd_addr  = head_ff;
      kind     = deq_pkg::KIND_OK;
      unique case (act)
         deq_pkg::ACT_PUSH_BACK: begin
            if (full) begin
               kind = deq_pkg::KIND_FULL;
            end else begin
               wr_req   = 1'b1;
               tail_in  = tail_next;
               count_in = count_ff + 1'b1;
            end
         end
         deq_pkg::ACT_PUSH_FRONT: begin
            if (full) begin
               kind = deq_pkg::KIND_FULL;
            end else begin
               wr_req   = 1'b1;
               wr_addr  = head_prev;
               head_in  = head_prev;
               count_in = count_ff + 1'b1;
            end
         end
         deq_pkg::ACT_SIZE: begin
            kind = deq_pkg::KIND_OK;
         end
         deq_pkg::ACT_POP_FRONT, deq_pkg::ACT_PEEK_FRONT: begin
            if (empty) begin
               kind = deq_pkg::KIND_EMPTY;
            end else begin
               kind   = deq_pkg::KIND_WORD;
               rd_req = 1'b1;
               if (act == deq_pkg::ACT_POP_FRONT) begin
                  head_in  = head_next;
                  count_in = count_ff - 1'b1;
               end
            end
         end
         deq_pkg::ACT_POP_BACK, deq_pkg::ACT_PEEK_BACK: begin
            rd_addr = tail_prev;
            if (empty) begin
               kind = deq_pkg::KIND_EMPTY;
            end else begin
               kind   = deq_pkg::KIND_WORD;
               rd_req = 1'b1;
               if (act == deq_pkg::ACT_POP_BACK) begin
                  tail_in  = tail_prev;
                  count_in = count_ff - 1'b1;
               end
            end
         end
         deq_pkg::ACT_CLEAR: begin
            head_in  = '0;
            tail_in  = '0;
            count_in = '0;
         end
         default: begin
            kind = deq_pkg::KIND_OK;
         end
      endcase
   end

   assign stat.read_hit = rd_req;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.accept) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   deq_ram #(
      .WIDTH (deq_pkg::WORD_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.accept && wr_req),
      .wr_addr (wr_addr),
      .wr_data (push_value),
      .rd_en   (cmd.accept && rd_req),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // response registers; on store reads the data lands in the cycle after the kind and fill
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff <= kind;
         fill_ff <= deq_pkg::FILL_W'(count_in);
         data_ff <= '0;
      end else if (cmd.load_read) begin
         data_ff <= rd_data;
      end
   end

   assign result_kind = kind_ff;
   assign data_word   = data_ff;
   assign fill_count  = fill_ff;

endmodule

// ----- hw/rtl/double_ended_queue_engine.sv -----
// Top level: bounded double-ended queue of signed words over a ring store.
// Responses are registered; pop/peek with data also pass the store read and ST_READ.
// Throughput: 1 request/cycle for push, size, clear and errors; reads stall in ST_READ.
// A new request is taken while the previous response waits, if it is drained that cycle.
// Reset (synchronous, high) empties the queue at once; the store itself is not cleared.
`include "assert_macros.svh"

module double_ended_queue_engine #(
   parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   deq_req_if.sink    req_ch,
   deq_rsp_if.source  rsp_ch
);

   deq_pkg::ctrl_cmd_type  cmd;
   deq_pkg::dp_status_type stat;

   // Controller owns the handshakes and the store read sequence.
   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath: head/tail pointers, count, store RAM and response payload.
   deq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .action      (req_ch.action),
      .push_value  (req_ch.push_value),
      .cmd         (cmd),
      .stat        (stat),
      .result_kind (rsp_ch.result_kind),
      .data_word   (rsp_ch.data_word),
      .fill_count  (rsp_ch.fill_count)
   );

   // Non-word responses carry a zero data word.
   `DEQ_ASSERT(a_zero_data, !(rsp_ch.valid && rsp_ch.result_kind != deq_pkg::KIND_WORD) || rsp_ch.data_word == '0, "non-word response with nonzero data")
   // A request that reads the store keeps ready low in the cycle after it is taken.
   `DEQ_ASSERT_NEXT(a_read_stall, req_ch.valid && req_ch.ready && stat.read_hit, !req_ch.ready, "request accepted during store read")
   // Read data is loaded only into an empty response slot.
   `DEQ_ASSERT(a_slot_free, !cmd.load_read || !rsp_ch.valid, "read data overwrote a pending response")

endmodule

// ----- tb/tb.sv -----
// Testbench for the double-ended queue engine: predicted responses checked in request order.
`timescale 1ns / 1ps

// One expected response, field for field.
typedef struct {
   deq_pkg::kind_type                  kind;
   logic signed [deq_pkg::WORD_W-1:0]  word;
   logic [deq_pkg::FILL_W-1:0]         fill;
} deq_result_type;

// Mirror of the ring store; predicts each response and checks it in order.
class deque_mirror #(int DEPTH = 1024);
   logic [deq_pkg::WORD_W-1:0] entry_store [DEPTH];
   int unsigned                head_slot;
   int unsigned                tail_slot;
   int unsigned                stored;
   deq_result_type             awaited[$];
   int unsigned                responses_seen;
   int unsigned                mismatches;

   function new();
      head_slot = 0;
      tail_slot = 0;
      stored    = 0;
   endfunction

   task report(string msg);
      $display("%t  mismatch: %s", $realtime, msg);
      mismatches++;
   endtask

   // Apply one accepted request to the mirror and queue its response.
   function void apply_command(deq_pkg::action_type act, logic [deq_pkg::WORD_W-1:0] value);
      deq_result_type r;
      int unsigned    last;
      r.kind = deq_pkg::KIND_OK;
      r.word = '0;
      case (act)
         deq_pkg::ACT_PUSH_BACK: begin
            if (stored >= DEPTH) begin
               r.kind = deq_pkg::KIND_FULL;
            end else begin
               entry_store[tail_slot] = value;
               tail_slot = (tail_slot + 1) % DEPTH;
               stored++;
            end
         end
         deq_pkg::ACT_PUSH_FRONT: begin
            if (stored >= DEPTH) begin
               r.kind = deq_pkg::KIND_FULL;
            end else begin
               head_slot = (head_slot + DEPTH - 1) % DEPTH;
               entry_store[head_slot] = value;
               stored++;
            end
         end
         deq_pkg::ACT_SIZE: begin
         end
         deq_pkg::ACT_POP_FRONT, deq_pkg::ACT_PEEK_FRONT: begin
            if (stored == 0) begin
               r.kind = deq_pkg::KIND_EMPTY;
            end else begin
               r.kind = deq_pkg::KIND_WORD;
               r.word = entry_store[head_slot];
               if (act == deq_pkg::ACT_POP_FRONT) begin
                  head_slot = (head_slot + 1) % DEPTH;
                  stored--;
               end
            end
         end
         deq_pkg::ACT_POP_BACK, deq_pkg::ACT_PEEK_BACK: begin
            if (stored == 0) begin
               r.kind = deq_pkg::KIND_EMPTY;
            end else begin
               last   = (tail_slot + DEPTH - 1) % DEPTH;
               r.kind = deq_pkg::KIND_WORD;
               r.word = entry_store[last];
               if (act == deq_pkg::ACT_POP_BACK) begin
                  tail_slot = last;
                  stored--;
               end
            end
         end
         default: begin
            head_slot = 0;
            tail_slot = 0;
            stored    = 0;
         end
      endcase
      r.fill = stored[deq_pkg::FILL_W-1:0];
      awaited = {awaited, r};
   endfunction

   // Compare one accepted response against the oldest prediction.
   task compare_response(logic [deq_pkg::KIND_W-1:0] kind, logic [deq_pkg::WORD_W-1:0] word,
                         logic [deq_pkg::FILL_W-1:0] fill);
      deq_result_type exp;
      responses_seen++;
      if (awaited.size() == 0) begin
         report($sformatf("response #%0d unexpected: kind %0d word %h fill %0d",
                          responses_seen, kind, word, fill));
         return;
      end
      exp = awaited[0];
      awaited.delete(0);
      if (kind !== exp.kind)
         report($sformatf("response #%0d kind %0d, expected %0d",
                          responses_seen, kind, exp.kind));
      if (word !== exp.word)
         report($sformatf("response #%0d word %h, expected %h",
                          responses_seen, word, exp.word));
      if (fill !== exp.fill)
         report($sformatf("response #%0d fill %0d, expected %0d",
                          responses_seen, fill, exp.fill));
   endtask

   function int unsigned outstanding();
      return awaited.size();
   endfunction
endclass

module tb;
   localparam int          DEPTH      = deq_pkg::DEPTH_DEFAULT;
   // ~1900 requests; the cap stays far above that even with stalls on each request
   localparam int unsigned CYCLE_CAP  = 200000;
   localparam int unsigned MIXED_REQS = 450;

   logic        clock = 1'b0;
   logic        reset;
   int unsigned cycle_count = 0;
   int          burst_left;

   deq_req_if req_if ();
   deq_rsp_if rsp_if ();

   deque_mirror #(DEPTH) mirror;

   double_ended_queue_engine #(.DEPTH(DEPTH)) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // 2 ns period
   always #1 clock = ~clock;

   // Watchdog: a hang or a lost response ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Response back-pressure. The mode rotates with the cycle count:
   // always ready, coin flip, fixed 3-of-7 stall, and mostly stalled.
   always @(negedge clock) begin
      case ((cycle_count / 256) % 4)
         0: rsp_if.ready = 1'b1;
         1: rsp_if.ready = $urandom_range(0, 1);
         2: rsp_if.ready = (cycle_count % 7) >= 3;
         default: rsp_if.ready = ($urandom_range(0, 3) == 0);
      endcase
   end

   // Handshakes are sampled at the rising edge, before the design's own
   // registers update, so requests and responses are seen in a fixed order.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            mirror.apply_command(deq_pkg::action_type'(req_if.action), req_if.push_value);
         if (rsp_if.valid && rsp_if.ready)
            mirror.compare_response(rsp_if.result_kind, rsp_if.data_word,
                                    rsp_if.fill_count);
      end
   end

   // Bursty sender: at a burst boundary drop valid for a random gap.
   // A zero gap merges two bursts into one unbroken stretch.
   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         gap        = $urandom_range(0, 5);
         burst_left = $urandom_range(1, 24);
         if (gap != 0) begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
   endtask

   // Present one request at the falling edge and hold it until taken.
   // Valid stays high on return so back-to-back requests have no bubble.
   task automatic send_command(deq_pkg::action_type act, logic [deq_pkg::WORD_W-1:0] value);
      pace_sender();
      req_if.valid      = 1'b1;
      req_if.action     = act;
      req_if.push_value = value;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Push words: mostly random, now and then one of the extremes.
   function automatic logic [deq_pkg::WORD_W-1:0] pick_word();
      case ($urandom_range(0, 15))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   // push_pct sets the push share; the rest spreads over size, pops and
   // peeks, with clear kept rare so the queue can grow.
   function automatic deq_pkg::action_type pick_action(int unsigned push_pct, bit with_clear);
      if ($urandom_range(0, 99) < push_pct)
         return $urandom_range(0, 1) ? deq_pkg::ACT_PUSH_FRONT : deq_pkg::ACT_PUSH_BACK;
      if (with_clear && $urandom_range(0, 49) == 0)
         return deq_pkg::ACT_CLEAR;
      return deq_pkg::action_type'($urandom_range(deq_pkg::ACT_SIZE, deq_pkg::ACT_PEEK_BACK));
   endfunction

   initial begin
      // Known values on every request input from time zero.
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.action     = deq_pkg::ACT_SIZE;
      req_if.push_value = '0;
      burst_left        = 0;
      mirror            = new();

      // synchronous reset, released at a falling edge
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: pops, peeks, size and a push on an empty queue, both ends with the
      // extreme words, a clear with entries present, and a wrap of the
      // head index below slot zero.
      send_command(deq_pkg::ACT_POP_FRONT,  pick_word());
      send_command(deq_pkg::ACT_POP_BACK,   pick_word());
      send_command(deq_pkg::ACT_PEEK_FRONT, pick_word());
      send_command(deq_pkg::ACT_PEEK_BACK,  pick_word());
      send_command(deq_pkg::ACT_SIZE,       32'hffff_ffff);
      send_command(deq_pkg::ACT_PUSH_BACK,  32'h7fff_ffff);
      send_command(deq_pkg::ACT_PUSH_FRONT, 32'h8000_0000);
      send_command(deq_pkg::ACT_PUSH_BACK,  32'hffff_ffff);
      send_command(deq_pkg::ACT_PUSH_FRONT, 32'h0000_0000);
      send_command(deq_pkg::ACT_SIZE,       32'h0000_0000);
      send_command(deq_pkg::ACT_PEEK_FRONT, 32'h0000_0000);
      send_command(deq_pkg::ACT_PEEK_BACK,  32'h0000_0000);
      send_command(deq_pkg::ACT_POP_BACK,   32'h0000_0000);
      send_command(deq_pkg::ACT_POP_FRONT,  32'h0000_0000);
      send_command(deq_pkg::ACT_PEEK_FRONT, 32'h0000_0000);
      send_command(deq_pkg::ACT_PEEK_BACK,  32'h0000_0000);
      send_command(deq_pkg::ACT_CLEAR,      32'h0000_0000);
      send_command(deq_pkg::ACT_SIZE,       32'h0000_0000);
      send_command(deq_pkg::ACT_PEEK_BACK,  32'h0000_0000);
      send_command(deq_pkg::ACT_PUSH_FRONT, 32'h5555_5555);
      send_command(deq_pkg::ACT_PUSH_BACK,  32'haaaa_aaaa);
      send_command(deq_pkg::ACT_POP_FRONT,  32'h0000_0000);
      send_command(deq_pkg::ACT_POP_FRONT,  32'h0000_0000);
      send_command(deq_pkg::ACT_POP_FRONT,  32'h0000_0000);

      // Mixed traffic at a shallow fill, clears included.
      repeat (MIXED_REQS) send_command(pick_action(45, 1'b1), pick_word());

      // Fill to the brim without clears, then hammer the full queue:
      // dropped pushes interleaved with pops that reopen a slot.
      send_command(deq_pkg::ACT_CLEAR, pick_word());
      while (mirror.stored < DEPTH) send_command(pick_action(92, 1'b0), pick_word());
      repeat (80) send_command(pick_action(60, 1'b0), pick_word());
      send_command(deq_pkg::ACT_SIZE, pick_word());

      // Clear a full queue and run mixed traffic once more.
      send_command(deq_pkg::ACT_CLEAR, pick_word());
      repeat (150) send_command(pick_action(45, 1'b1), pick_word());
      req_if.valid = 1'b0;

      // Drain, then allow the read latency for any stray response.
      while (mirror.outstanding() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (mirror.mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/deq_pkg.sv
hw/rtl/deq_ifs.sv
hw/rtl/deq_ram.sv
hw/rtl/deq_ctrl.sv
hw/rtl/deq_dpath.sv
hw/rtl/double_ended_queue_engine.sv
tb/tb.sv
